@@ hdl/bad_pkg.sv @@
// Shared types and constants of the box-average image downscaler.
// Used by the top level, both checkers and the testbench; depends on nothing else.
package bad_pkg;

   localparam int PIXEL_BITS   = 16;  // width of one colour channel
   localparam int SUM_BITS     = 40;  // width of one column-sum channel
   localparam int CTR_BITS     = 12;  // source and output position counters
   localparam int REG_BITS     = 13;  // width of each configuration register
   localparam int CSR_IDX_BITS = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_INPUT_WIDTH  = 2'd0,
      CSR_INPUT_HEIGHT = 2'd1,
      CSR_LIMIT        = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FRAME,
      ST_DIV_OW,
      ST_DIV_OH,
      ST_DIV_CB0,
      ST_DIV_RB0,
      ST_DECIDE,
      ST_DIV_CS,
      ST_ACC,
      ST_CNT,
      ST_DIV_R,
      ST_DIV_G,
      ST_DIV_B,
      ST_EMIT,
      ST_ADVANCE,
      ST_DIV_CBE,
      ST_DIV_RBE
   } bad_state_type;

endpackage

@@ hdl/box_average_image_downscaler.sv @@
// Top level of the box-average image downscaler: sequencer, counters and
// output register. Depends on bad_pkg, bad_divider and bad_line_store.
//
//   channel | direction | payload, lowest bits first
//   --------+-----------+-----------------------------------------------
//   req_    | in        | tdata: red_in, green_in, blue_in
//   rsp_    | out       | tdata: red_out, green_out, blue_out; tlast: frame_end
//   csr_    | in        | index 0 input_width, 1 input_height, 2 longest_side_limit
//
// A pass-through pixel runs from idle through the frame, decide, emit and
// advance states. A scaled pixel takes runs of the shared bit-serial divider:
// one for its column bin start, one more when it closes a column bin or ends
// a row, another when that row also closes a row bin, three with the count and
// emit states when it completes an output pixel, and four more at frame start.
// Reset is synchronous and clears the counters, output sizes, bin edges and the
// output valid flag; the line store needs no clearing. A stall on the result
// side only holds the sequencer when a new result is ready to be loaded.
module box_average_image_downscaler #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bad_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [bad_pkg::REG_BITS-1:0]       csr_data,
   // input pixels
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [3*bad_pkg::PIXEL_BITS-1:0]   req_tdata,  // red_in, green_in, blue_in
   // output pixels
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [3*bad_pkg::PIXEL_BITS-1:0]   rsp_tdata,  // red_out, green_out, blue_out
   output logic                               rsp_tlast   // frame_end
);

   import bad_pkg::*;

   // Sizes follow the largest frame side; edges are i * side with i < 2^13.
   localparam int SZ_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int SZ_W   = $clog2(SZ_MAX + 1);
   localparam int EW     = REG_BITS + SZ_W;
   localparam int CW     = 2 * EW;
   localparam int DW     = (CW + 1 > SUM_BITS + 1) ? CW + 1 : SUM_BITS + 1;
   localparam int IW     = $clog2(MAX_WIDTH);
   localparam int LW     = 3 * SUM_BITS;

   // Configuration registers.
   logic [REG_BITS-1:0] cfg_w_ff, cfg_h_ff, cfg_lim_ff;

   // Sequencer and frame state.
   bad_state_type       state_ff, state_in;
   logic [SZ_W-1:0]     w_ff, w_in, h_ff, h_in;
   logic [REG_BITS-1:0] lim_ff, lim_in;
   logic [PIXEL_BITS-1:0] pix_r_ff, pix_r_in, pix_g_ff, pix_g_in, pix_b_ff, pix_b_in;
   logic [CTR_BITS-1:0] sc_ff, sc_in, sr_ff, sr_in, oc_ff, oc_in, or_ff, or_in;
   logic [CTR_BITS-1:0] rbs_ff, rbs_in;
   logic [EW-1:0]       cbe_ff, cbe_in, rbe_ff, rbe_in, cs_ff, cs_in;
   logic [SZ_W-1:0]     ow_ff, ow_in, oh_ff, oh_in;
   logic [SUM_BITS-1:0] sum_r_ff, sum_r_in, sum_g_ff, sum_g_in, sum_b_ff, sum_b_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                col_done_ff, col_done_in, row_step_ff, row_step_in;
   logic [PIXEL_BITS-1:0] res_r_ff, res_r_in, res_g_ff, res_g_in, res_b_ff, res_b_in;
   logic                res_last_ff, res_last_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [3*PIXEL_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   // Helpers.
   logic [SZ_W-1:0]     w_clamp, h_clamp, longest;
   logic                scale_off, last_col, last_row, first_px;
   logic [SZ_W+REG_BITS-1:0] prod_w, prod_h;
   logic [REG_BITS-1:0] edge_i;
   logic [SZ_W-1:0]     edge_side;
   logic [EW-1:0]       edge_prod, cols, rows;
   logic [CTR_BITS-1:0] oc_inc, or_inc, sr_inc;
   logic [SUM_BITS-1:0] new_r, new_g, new_b;
   logic                div_start, div_done;
   logic [DW-1:0]       div_dvd, div_dsr, div_quo;
   logic                mem_rd_en, mem_wr_en;
   logic [LW-1:0]       mem_rd_data;

   // A size register of zero reads as one; a larger one saturates.
   always_comb begin
      if (cfg_w_ff == '0) begin
         w_clamp = SZ_W'(1);
      end else if (32'(cfg_w_ff) > MAX_WIDTH) begin
         w_clamp = SZ_W'(MAX_WIDTH);
      end else begin
         w_clamp = SZ_W'(cfg_w_ff);
      end
      if (cfg_h_ff == '0) begin
         h_clamp = SZ_W'(1);
      end else if (32'(cfg_h_ff) > MAX_HEIGHT) begin
         h_clamp = SZ_W'(MAX_HEIGHT);
      end else begin
         h_clamp = SZ_W'(cfg_h_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_w_ff   <= REG_BITS'(1);
         cfg_h_ff   <= REG_BITS'(1);
         cfg_lim_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_INPUT_WIDTH:  cfg_w_ff   <= csr_data;
            CSR_INPUT_HEIGHT: cfg_h_ff   <= csr_data;
            CSR_LIMIT:        cfg_lim_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Quantities of the pixel in hand, taken from the latched geometry.
   assign longest   = (w_ff > h_ff) ? w_ff : h_ff;
   assign scale_off = (lim_ff == '0) || (32'(longest) <= 32'(lim_ff));
   assign last_col  = (32'(sc_ff) + 32'd1) >= 32'(w_ff);
   assign last_row  = (32'(sr_ff) + 32'd1) >= 32'(h_ff);
   assign prod_w    = w_ff * lim_ff;
   assign prod_h    = h_ff * lim_ff;
   assign edge_prod = edge_i * edge_side;
   assign oc_inc    = oc_ff + CTR_BITS'(1);
   assign or_inc    = or_ff + CTR_BITS'(1);
   assign sr_inc    = sr_ff + CTR_BITS'(1);
   assign first_px  = (sr_ff == rbs_ff) && (EW'(sc_ff) == cs_ff);
   assign cols      = (cbe_ff > cs_ff) ? cbe_ff - cs_ff : EW'(1);
   assign rows      = (rbe_ff > EW'(rbs_ff)) ? rbe_ff - EW'(rbs_ff) : EW'(1);

   // The first pixel of a bin restarts the column sum.
   assign new_r = first_px ? SUM_BITS'(pix_r_ff)
                           : mem_rd_data[SUM_BITS-1:0] + SUM_BITS'(pix_r_ff);
   assign new_g = first_px ? SUM_BITS'(pix_g_ff)
                           : mem_rd_data[2*SUM_BITS-1:SUM_BITS] + SUM_BITS'(pix_g_ff);
   assign new_b = first_px ? SUM_BITS'(pix_b_ff)
                           : mem_rd_data[3*SUM_BITS-1:2*SUM_BITS] + SUM_BITS'(pix_b_ff);

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      lim_in       = lim_ff;
      pix_r_in     = pix_r_ff;
      pix_g_in     = pix_g_ff;
      pix_b_in     = pix_b_ff;
      sc_in        = sc_ff;
      sr_in        = sr_ff;
      oc_in        = oc_ff;
      or_in        = or_ff;
      rbs_in       = rbs_ff;
      cbe_in       = cbe_ff;
      rbe_in       = rbe_ff;
      cs_in        = cs_ff;
      ow_in        = ow_ff;
      oh_in        = oh_ff;
      sum_r_in     = sum_r_ff;
      sum_g_in     = sum_g_ff;
      sum_b_in     = sum_b_ff;
      cnt_in       = cnt_ff;
      col_done_in  = col_done_ff;
      row_step_in  = row_step_ff;
      res_r_in     = res_r_ff;
      res_g_in     = res_g_ff;
      res_b_in     = res_b_ff;
      res_last_in  = res_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      edge_i       = '0;
      edge_side    = '0;
      div_start    = 1'b0;
      div_dvd      = '0;
      div_dsr      = DW'(1);
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               w_in     = w_clamp;
               h_in     = h_clamp;
               lim_in   = cfg_lim_ff;
               pix_r_in = req_tdata[PIXEL_BITS-1:0];
               pix_g_in = req_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
               pix_b_in = req_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS];
               state_in = ST_FRAME;
            end
         end
         ST_FRAME: begin
            state_in = ST_DECIDE;
            if (sc_ff == '0 && sr_ff == '0) begin
               or_in = '0;
               oc_in = '0;
               if (scale_off) begin
                  ow_in = '0;
                  oh_in = '0;
               end else begin
                  // Output width rounded to nearest, ties upwards.
                  div_start = 1'b1;
                  div_dvd   = DW'({prod_w, 1'b0}) + DW'(longest);
                  div_dsr   = DW'({longest, 1'b0});
                  state_in  = ST_DIV_OW;
               end
            end
         end
         ST_DIV_OW: begin
            if (div_done) begin
               ow_in     = (div_quo == '0) ? SZ_W'(1) : div_quo[SZ_W-1:0];
               div_start = 1'b1;
               div_dvd   = DW'({prod_h, 1'b0}) + DW'(longest);
               div_dsr   = DW'({longest, 1'b0});
               state_in  = ST_DIV_OH;
            end
         end
         ST_DIV_OH: begin
            if (div_done) begin
               oh_in     = (div_quo == '0) ? SZ_W'(1) : div_quo[SZ_W-1:0];
               edge_i    = REG_BITS'(1);
               edge_side = w_ff;
               div_start = 1'b1;
               div_dvd   = DW'(edge_prod);
               div_dsr   = DW'(ow_ff);
               state_in  = ST_DIV_CB0;
            end
         end
         ST_DIV_CB0: begin
            if (div_done) begin
               cbe_in    = div_quo[EW-1:0];
               rbs_in    = '0;
               edge_i    = REG_BITS'(1);
               edge_side = h_ff;
               div_start = 1'b1;
               div_dvd   = DW'(edge_prod);
               div_dsr   = DW'(oh_ff);
               state_in  = ST_DIV_RB0;
            end
         end
         ST_DIV_RB0: begin
            if (div_done) begin
               rbe_in   = div_quo[EW-1:0];
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (ow_ff == '0) begin
               res_r_in    = pix_r_ff;
               res_g_in    = pix_g_ff;
               res_b_in    = pix_b_ff;
               res_last_in = last_col && last_row;
               state_in    = ST_EMIT;
            end else begin
               // Start of the current column bin, and the sum read for it.
               edge_i    = REG_BITS'(oc_ff);
               edge_side = w_ff;
               div_start = 1'b1;
               div_dvd   = DW'(edge_prod);
               div_dsr   = DW'(ow_ff);
               mem_rd_en = 1'b1;
               state_in  = ST_DIV_CS;
            end
         end
         ST_DIV_CS: begin
            if (div_done) begin
               cs_in    = div_quo[EW-1:0];
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            mem_wr_en   = 1'b1;
            sum_r_in    = new_r;
            sum_g_in    = new_g;
            sum_b_in    = new_b;
            cnt_in      = cols * rows;
            col_done_in = (EW'(sc_ff) + EW'(1)) >= cbe_ff;
            if (col_done_in && (EW'(sr_ff) + EW'(1)) >= rbe_ff) begin
               state_in = ST_CNT;
            end else begin
               state_in = ST_ADVANCE;
            end
         end
         ST_CNT: begin
            div_start = 1'b1;
            div_dvd   = DW'(sum_r_ff) + DW'(cnt_ff >> 1);
            div_dsr   = DW'(cnt_ff);
            state_in  = ST_DIV_R;
         end
         ST_DIV_R: begin
            if (div_done) begin
               res_r_in  = div_quo[PIXEL_BITS-1:0];
               div_start = 1'b1;
               div_dvd   = DW'(sum_g_ff) + DW'(cnt_ff >> 1);
               div_dsr   = DW'(cnt_ff);
               state_in  = ST_DIV_G;
            end
         end
         ST_DIV_G: begin
            if (div_done) begin
               res_g_in  = div_quo[PIXEL_BITS-1:0];
               div_start = 1'b1;
               div_dvd   = DW'(sum_b_ff) + DW'(cnt_ff >> 1);
               div_dsr   = DW'(cnt_ff);
               state_in  = ST_DIV_B;
            end
         end
         ST_DIV_B: begin
            if (div_done) begin
               res_b_in    = div_quo[PIXEL_BITS-1:0];
               res_last_in = last_col && last_row;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Load the output register once the previous transaction has gone.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_b_ff, res_g_ff, res_r_ff};
               rsp_last_in  = res_last_ff;
               state_in     = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            row_step_in = 1'b0;
            state_in    = ST_IDLE;
            if (!last_col) begin
               sc_in = sc_ff + CTR_BITS'(1);
               if (ow_ff != '0 && col_done_ff) begin
                  oc_in     = oc_inc;
                  edge_i    = {1'b0, oc_inc} + REG_BITS'(1);
                  edge_side = w_ff;
                  div_start = 1'b1;
                  div_dvd   = DW'(edge_prod);
                  div_dsr   = DW'(ow_ff);
                  state_in  = ST_DIV_CBE;
               end
            end else begin
               sc_in = '0;
               oc_in = '0;
               if (last_row) begin
                  sr_in = '0;
               end else begin
                  sr_in       = sr_inc;
                  row_step_in = (ow_ff != '0) && (EW'(sr_inc) >= rbe_ff);
               end
               if (ow_ff != '0) begin
                  edge_i    = REG_BITS'(1);
                  edge_side = w_ff;
                  div_start = 1'b1;
                  div_dvd   = DW'(edge_prod);
                  div_dsr   = DW'(ow_ff);
                  state_in  = ST_DIV_CBE;
               end
            end
         end
         ST_DIV_CBE: begin
            if (div_done) begin
               cbe_in   = div_quo[EW-1:0];
               state_in = ST_IDLE;
               if (row_step_ff) begin
                  or_in     = or_inc;
                  rbs_in    = rbe_ff[CTR_BITS-1:0];
                  edge_i    = {1'b0, or_inc} + REG_BITS'(1);
                  edge_side = h_ff;
                  div_start = 1'b1;
                  div_dvd   = DW'(edge_prod);
                  div_dsr   = DW'(oh_ff);
                  state_in  = ST_DIV_RBE;
               end
            end
         end
         ST_DIV_RBE: begin
            if (div_done) begin
               rbe_in   = div_quo[EW-1:0];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sc_ff        <= '0;
         sr_ff        <= '0;
         oc_ff        <= '0;
         or_ff        <= '0;
         rbs_ff       <= '0;
         cbe_ff       <= '0;
         rbe_ff       <= '0;
         ow_ff        <= '0;
         oh_ff        <= '0;
         col_done_ff  <= 1'b0;
         row_step_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sc_ff        <= sc_in;
         sr_ff        <= sr_in;
         oc_ff        <= oc_in;
         or_ff        <= or_in;
         rbs_ff       <= rbs_in;
         cbe_ff       <= cbe_in;
         rbe_ff       <= rbe_in;
         ow_ff        <= ow_in;
         oh_ff        <= oh_in;
         col_done_ff  <= col_done_in;
         row_step_ff  <= row_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      h_ff        <= h_in;
      lim_ff      <= lim_in;
      pix_r_ff    <= pix_r_in;
      pix_g_ff    <= pix_g_in;
      pix_b_ff    <= pix_b_in;
      cs_ff       <= cs_in;
      sum_r_ff    <= sum_r_in;
      sum_g_ff    <= sum_g_in;
      sum_b_ff    <= sum_b_in;
      cnt_ff      <= cnt_in;
      res_r_ff    <= res_r_in;
      res_g_ff    <= res_g_in;
      res_b_ff    <= res_b_in;
      res_last_ff <= res_last_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // The output column never reaches MAX_WIDTH, so it addresses the store
   // directly.
   bad_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (IW),
      .DW    (LW)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (IW'(oc_ff)),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (IW'(oc_ff)),
      .wr_data ({new_b, new_g, new_r})
   );

   bad_divider #(
      .DW (DW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ hdl/bad_divider.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Stand-alone; no package needed.
module bad_divider #(
   parameter int DW = 53
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int SW = $clog2(DW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [SW-1:0] step_ff, step_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [DW-1:0] dsr_ff, dsr_in;
   logic [DW:0]   rem_shift;
   logic [DW:0]   rem_diff;
   logic          fits;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DW-1]};
      fits      = rem_shift >= {1'b0, dsr_ff};
      rem_diff  = rem_shift - {1'b0, dsr_ff};
      busy_in   = busy_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dsr_in    = dsr_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         step_in = SW'(DW);
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so it fits in DW bits.
         rem_in  = fits ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
         quo_in  = {quo_ff[DW-2:0], fits};
         step_in = step_ff - SW'(1);
         if (step_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ hdl/bad_line_store.sv @@
// Line store of the per-column channel sums: one synchronous RAM,
// one write and one registered read port. No package needed.
module bad_line_store #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 120
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/bad_checker.sv @@
// Port-level checks of the box-average image downscaler, bound to the top.
// Depends on bad_pkg for the channel widths.
module bad_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [3*bad_pkg::PIXEL_BITS-1:0] rsp_tdata,
   input logic                             rsp_tlast
);

   import bad_pkg::*;

   // No result survives a reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result still valid after reset");

   // A stalled result transaction holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // One pixel is worked on at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again before the pixel was finished");

   // A new result appears only while a pixel is still being finished.
   a_result_in_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !req_tready)
      else $error("result appeared while idle");

endmodule

bind box_average_image_downscaler bad_checker u_bad_checker (.*);

@@ test/box_average_image_downscaler_checker.sv @@
// Checker of the box-average image downscaler: watches the three channels,
// predicts each result from its own copy of the frame state and compares.
// Depends on bad_pkg for the register index codes.
module box_average_image_downscaler_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_valid,
   input  logic                                   csr_ready,
   input  logic [bad_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [bad_pkg::REG_BITS-1:0]           csr_data,
   input  logic                                   req_tvalid,
   input  logic                                   req_tready,
   input  logic [3*bad_pkg::PIXEL_BITS-1:0]       req_tdata,
   input  logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic [3*bad_pkg::PIXEL_BITS-1:0]       rsp_tdata,
   input  logic                                   rsp_tlast,
   output int                                     mismatches,
   output int                                     pending
);

   import bad_pkg::*;

   localparam int unsigned LINE_MAX   = 4096;
   localparam int unsigned ROWS_MAX   = 4096;
   localparam logic [SUM_BITS-1:0] SUM_MASK = '1;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] red;
      logic [PIXEL_BITS-1:0] green;
      logic [PIXEL_BITS-1:0] blue;
      logic                  frame_end;
   } out_pixel_type;

   out_pixel_type expected_pixels[$];

   int unsigned width_reg, height_reg, limit_reg;
   logic [SUM_BITS-1:0] red_sum [LINE_MAX];
   logic [SUM_BITS-1:0] green_sum [LINE_MAX];
   logic [SUM_BITS-1:0] blue_sum [LINE_MAX];
   int unsigned src_col, src_row, out_col, out_row;
   int unsigned col_end, row_start, row_end, out_w, out_h;

   function automatic int unsigned limit_size(int unsigned v, int unsigned top);
      if (v == 0) return 1;
      return (v > top) ? top : v;
   endfunction

   // Other side rounded to nearest with ties up, never below one.
   function automatic int unsigned shrink_side(int unsigned side, int unsigned lim,
                                               int unsigned longest);
      longint unsigned q;
      q = (2 * longint'(side) * lim + longest) / (2 * longint'(longest));
      return (q < 1) ? 1 : int'(q);
   endfunction

   function automatic int unsigned edge_of_bin(int unsigned i, int unsigned n_in,
                                               int unsigned n_out);
      return int'((longint'(i) * n_in) / n_out);
   endfunction

   function automatic logic [PIXEL_BITS-1:0] rounded_mean(logic [SUM_BITS-1:0] s,
                                                          longint unsigned cnt);
      longint unsigned q;
      q = (longint'(s) + cnt / 2) / cnt;
      return q[PIXEL_BITS-1:0];
   endfunction

   task automatic predict_pixel(input logic [3*PIXEL_BITS-1:0] pix);
      int unsigned w, h, longest, idx, col_first;
      logic [PIXEL_BITS-1:0] r, g, b;
      logic end_col, end_row, col_done, opens_bin;
      longint unsigned n_cols, n_rows, cnt;
      out_pixel_type e;
      w = limit_size(width_reg, LINE_MAX);
      h = limit_size(height_reg, ROWS_MAX);
      r = pix[0 +: PIXEL_BITS];
      g = pix[PIXEL_BITS +: PIXEL_BITS];
      b = pix[2*PIXEL_BITS +: PIXEL_BITS];

      // Frame geometry is latched from the registers at the first pixel.
      if (src_col == 0 && src_row == 0) begin
         longest = (w > h) ? w : h;
         out_row = 0;
         out_col = 0;
         if (limit_reg == 0 || longest <= limit_reg) begin
            out_w = 0;
            out_h = 0;
         end else begin
            out_w     = shrink_side(w, limit_reg, longest);
            out_h     = shrink_side(h, limit_reg, longest);
            col_end   = edge_of_bin(1, w, out_w);
            row_start = 0;
            row_end   = edge_of_bin(1, h, out_h);
         end
      end

      end_col = (src_col + 1 >= w);
      end_row = (src_row + 1 >= h);

      if (out_w == 0) begin
         e = '{red: r, green: g, blue: b, frame_end: end_col && end_row};
         expected_pixels.push_back(e);
      end else begin
         idx       = out_col % LINE_MAX;
         col_first = edge_of_bin(out_col, w, out_w);
         opens_bin = (src_row == row_start) && (src_col == col_first);
         if (opens_bin) begin
            red_sum[idx]   = SUM_BITS'(r);
            green_sum[idx] = SUM_BITS'(g);
            blue_sum[idx]  = SUM_BITS'(b);
         end else begin
            red_sum[idx]   = (red_sum[idx] + r) & SUM_MASK;
            green_sum[idx] = (green_sum[idx] + g) & SUM_MASK;
            blue_sum[idx]  = (blue_sum[idx] + b) & SUM_MASK;
         end
         col_done = (src_col + 1 >= col_end);
         if (col_done && src_row + 1 >= row_end) begin
            n_cols = (col_end > col_first) ? col_end - col_first : 1;
            n_rows = (row_end > row_start) ? row_end - row_start : 1;
            cnt    = n_cols * n_rows;
            e.red       = rounded_mean(red_sum[idx], cnt);
            e.green     = rounded_mean(green_sum[idx], cnt);
            e.blue      = rounded_mean(blue_sum[idx], cnt);
            e.frame_end = end_col && end_row;
            expected_pixels.push_back(e);
         end
         if (col_done && !end_col) begin
            out_col = (out_col + 1) & 32'hFFF;
            col_end = edge_of_bin(out_col + 1, w, out_w);
         end
      end

      if (end_col) begin
         src_col = 0;
         out_col = 0;
         if (out_w != 0) col_end = edge_of_bin(1, w, out_w);
         if (end_row) begin
            src_row = 0;
         end else begin
            src_row = (src_row + 1) & 32'hFFF;
            if (out_w != 0 && src_row >= row_end) begin
               out_row   = (out_row + 1) & 32'hFFF;
               row_start = row_end & 32'hFFF;
               row_end   = edge_of_bin(out_row + 1, h, out_h);
            end
         end
      end else begin
         src_col = (src_col + 1) & 32'hFFF;
      end
   endtask

   task automatic compare_pixel();
      out_pixel_type e, a;
      a = '{red: rsp_tdata[0 +: PIXEL_BITS], green: rsp_tdata[PIXEL_BITS +: PIXEL_BITS],
            blue: rsp_tdata[2*PIXEL_BITS +: PIXEL_BITS], frame_end: rsp_tlast};
      if (expected_pixels.size() == 0) begin
         $display("%0t: unexpected output pixel %h/%h/%h last %b", $time,
                  a.red, a.green, a.blue, a.frame_end);
         mismatches++;
      end else begin
         e = expected_pixels.pop_front();
         if (a.red !== e.red) begin
            $display("%0t: red expected %h actual %h", $time, e.red, a.red);
            mismatches++;
         end
         if (a.green !== e.green) begin
            $display("%0t: green expected %h actual %h", $time, e.green, a.green);
            mismatches++;
         end
         if (a.blue !== e.blue) begin
            $display("%0t: blue expected %h actual %h", $time, e.blue, a.blue);
            mismatches++;
         end
         if (a.frame_end !== e.frame_end) begin
            $display("%0t: frame_end expected %b actual %b", $time, e.frame_end,
                     a.frame_end);
            mismatches++;
         end
      end
   endtask

   initial begin
      mismatches = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         width_reg  = 1;
         height_reg = 1;
         limit_reg  = 0;
         src_col = 0; src_row = 0; out_col = 0; out_row = 0;
         col_end = 0; row_start = 0; row_end = 0; out_w = 0; out_h = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_INPUT_WIDTH:  width_reg  = csr_data;
               CSR_INPUT_HEIGHT: height_reg = csr_data;
               CSR_LIMIT:        limit_reg  = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_pixel(req_tdata);
         if (rsp_tvalid && rsp_tready) compare_pixel();
      end
      pending = expected_pixels.size();
   end

endmodule

@@ test/box_average_image_downscaler_tb.sv @@
// Testbench top of the box-average image downscaler: clock, reset, stimulus
// and verdict. Depends on bad_pkg, the block and the checker module.
module box_average_image_downscaler_tb;
   import bad_pkg::*;

   // A scaled pixel can cost up to ten divider runs, so the settling
   // pause after the last expected result is kept well above that.
   localparam int SETTLE_CYCLES = 1500;
   localparam int CYCLE_LIMIT   = 6000000;
   localparam int RANDOM_PIXELS = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [REG_BITS-1:0] csr_data = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [3*PIXEL_BITS-1:0] req_tdata = '0;   // red_in, green_in, blue_in
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [3*PIXEL_BITS-1:0] rsp_tdata;        // red_out, green_out, blue_out
   logic rsp_tlast;                           // frame_end

   int mismatches, pending;
   int cycle_count = 0;
   // Percentages of cycles in which the sender idles and the receiver stalls.
   int send_gap_pct = 0;
   int sink_stall_pct = 0;
   int random_sent = 0;
   int phase_no = 0;

   always #4 clock = ~clock;

   box_average_image_downscaler dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   box_average_image_downscaler_checker checker_i (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .mismatches(mismatches), .pending(pending)
   );

   // The receiver stalls at random, at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // Watchdog: a run that hangs is ended as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("box_average_image_downscaler test failed");
         $finish;
      end
   end

   // Step through the four idling patterns, one per phase: none, sender
   // mostly idle, receiver mostly stalled, and both idling 26 percent of the time.
   task automatic next_idling();
      case (phase_no % 4)
         0: begin send_gap_pct = 0;  sink_stall_pct = 0;  end
         1: begin send_gap_pct = 88; sink_stall_pct = 0;  end
         2: begin send_gap_pct = 0;  sink_stall_pct = 88; end
         default: begin send_gap_pct = 26; sink_stall_pct = 26; end
      endcase
      phase_no++;
   endtask

   // Wait until every expected result has arrived and the sequencer has
   // had time to finish any pixel that produced none.
   task automatic wait_idle();
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [REG_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_frame(input int w, input int h, input int lim);
      wait_idle();
      write_reg(CSR_INPUT_WIDTH, REG_BITS'(w));
      write_reg(CSR_INPUT_HEIGHT, REG_BITS'(h));
      write_reg(CSR_LIMIT, REG_BITS'(lim));
      next_idling();
   endtask

   // One pixel transaction; idle cycles are inserted before it at random.
   task automatic send_pixel(input logic [PIXEL_BITS-1:0] r, input logic [PIXEL_BITS-1:0] g,
                             input logic [PIXEL_BITS-1:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      do @(posedge clock); while (!req_tready);
   endtask

   function automatic logic [PIXEL_BITS-1:0] any_channel();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         default: return PIXEL_BITS'($urandom);
      endcase
   endfunction

   // Whole frames of random content; sizes are the effective ones.
   task automatic send_frames(input int w, input int h, input int n);
      repeat (n * w * h) begin
         send_pixel(any_channel(), any_channel(), any_channel());
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      int w, h, lim, longest, n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Pass-through of single-pixel frames with extreme channel values.
      set_frame(1, 1, 0);
      send_pixel('0, '1, 16'hAAAA);
      send_pixel('1, '0, 16'h5555);
      send_pixel(16'h5555, 16'hAAAA, '1);
      req_tvalid <= 1'b0;

      // Size registers of zero are read as one; a limit equal to the
      // longer side leaves the frame unscaled.
      set_frame(0, 0, 1);
      send_pixel(16'h1234, 16'h8001, 16'h7FFE);
      req_tvalid <= 1'b0;

      // Downscale 4x2 to 2x1, with full-scale values to test the rounding.
      set_frame(4, 2, 2);
      send_pixel('1, '1, '0);
      send_pixel('1, '0, '1);
      send_pixel('0, '1, '1);
      send_pixel('1, '1, '1);
      send_pixel('1, '0, '0);
      send_pixel('0, '0, '1);
      send_pixel('1, '1, 16'h0001);
      send_pixel('0, '1, 16'h0001);
      req_tvalid <= 1'b0;

      // Width lowered in the middle of a pass-through frame of 4x3: five
      // pixels in, the row ends early and the frame closes three pixels on.
      set_frame(4, 3, 0);
      repeat (5) send_pixel(any_channel(), any_channel(), any_channel());
      req_tvalid <= 1'b0;
      wait_idle();
      write_reg(CSR_INPUT_WIDTH, REG_BITS'(2));
      write_reg(CSR_LIMIT, REG_BITS'(1));
      repeat (3) send_pixel(any_channel(), any_channel(), any_channel());
      req_tvalid <= 1'b0;

      // Random frames, mostly small and mostly scaled.
      while (random_sent < RANDOM_PIXELS) begin
         w = $urandom_range(1, 16);
         h = $urandom_range(1, 16);
         longest = (w > h) ? w : h;
         lim = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, longest + 1);
         n = $urandom_range(1, 3);
         set_frame(w, h, lim);
         send_frames(w, h, n);
         random_sent += n * w * h;
      end

      // Extremes of the size registers. A width or height above the line
      // length saturates, so a limit of 4096 leaves the frame unscaled; the
      // frame is then closed early by lowering that size register.
      set_frame(8191, 2, 4096);
      repeat (5) send_pixel(any_channel(), any_channel(), any_channel());
      req_tvalid <= 1'b0;
      wait_idle();
      write_reg(CSR_INPUT_WIDTH, REG_BITS'(1));
      repeat (2) send_pixel(any_channel(), any_channel(), any_channel());
      req_tvalid <= 1'b0;
      set_frame(1, 8191, 4096);
      repeat (3) send_pixel(any_channel(), any_channel(), any_channel());
      req_tvalid <= 1'b0;
      wait_idle();
      write_reg(CSR_INPUT_HEIGHT, REG_BITS'(4));
      send_pixel(any_channel(), any_channel(), any_channel());
      req_tvalid <= 1'b0;

      // Strong reductions, and a limit far above the frame.
      set_frame(40, 3, 1);
      send_frames(40, 3, 2);
      set_frame(100, 2, 7);
      send_frames(100, 2, 1);
      set_frame(5, 5, 8191);
      send_frames(5, 5, 1);

      wait_idle();
      if (mismatches == 0 && pending == 0) begin
         $display("box_average_image_downscaler test passed");
      end else begin
         $display("box_average_image_downscaler test failed");
      end
      $finish;
   end

endmodule
